// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the sensor compensation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define TSC_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define TSC_ASSERT(label, prop, msg)
`define TSC_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ----- rtl/tsc_pkg.sv -----
// Types, constants and helper functions of the sensor compensation pipeline.
`timescale 1ns / 1ps
package tsc_pkg;

    localparam int FE_DEPTH   = 11;
    localparam int DIV_STAGES = 64;
    localparam int BE_DEPTH   = 7;

    localparam logic [32:0] PRESS_T_OFFSET = 33'd128000;
    localparam logic [31:0] HUM_T_OFFSET   = 32'd76800;
    localparam logic [31:0] HUM_CLAMP      = 32'd419430400;
    localparam logic [20:0] PRESS_FULL     = 21'd1048576;
    localparam logic [31:0] HUM_Y_BIAS     = 32'd2097152;
    localparam logic [16:0] PRESS_K3125    = 17'd3125;
    // Reciprocal of 100 scaled by 2^37, exact for every 32-bit magnitude.
    localparam logic [31:0] RECIP_100      = 32'h51EB_851F;
    localparam int          RECIP_SHIFT    = 37;

    typedef enum logic [2:0] {
        CFG_TEMP_CAL = 3'd0,
        CFG_PRESS_A  = 3'd1,
        CFG_PRESS_B  = 3'd2,
        CFG_PRESS_C  = 3'd3,
        CFG_HUM_CAL  = 3'd4
    } cfg_idx_e;

    // Results that ride alongside the pressure division.
    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
        logic        neg;
        logic        dz;
    } side_t;

    typedef struct packed {
        logic [63:0] ua;
        logic [63:0] ub;
        side_t       side;
    } div_in_t;

    typedef struct packed {
        logic [63:0] qu;
        side_t       side;
    } div_out_t;

    // Low 64 bits of a 64-bit word times a signed 17-bit factor.
    function automatic logic [63:0] mul_lo(logic [63:0] a, logic signed [16:0] b);
        logic signed [49:0] pl;
        logic signed [49:0] ph;
        pl = $signed({1'b0, a[31:0]}) * b;
        ph = $signed({1'b0, a[63:32]}) * b;
        return 64'(pl) + {ph[31:0], 32'd0};
    endfunction

endpackage

// ----- rtl/tph_sensor_compensation.sv -----
// Top level of the temperature, pressure and humidity compensation pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// This block applies the standard integer compensation to one raw pressure,
// temperature and humidity sample per input transaction and returns one
// result transaction with temperature in hundredths of a degree, pressure
// (Q24.8 pascal cut to 32 bits, divided by 100) and humidity in Q22.10.
// It is a fully pipelined design: a new transaction can be taken on every
// clock cycle while the result side is not stalled, and each one passes
// through 11 front stages, 64 divider stages and 7 back stages. Most of
// that depth is the 64-bit pressure division, one quotient bit per stage.
// The whole pipeline advances only when the result register is empty or
// being taken, so a stall on the result side holds every stage in place.
// Calibration registers are written through the cfg port; write them only
// while no transaction is in flight. A zero pressure divisor yields a
// pressure of 0 and sets the tuser flag of that result.
module tph_sensor_compensation import tsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Calibration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // Raw sample input.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [19:0] raw_pressure, [39:20] raw_temperature, [55:40] raw_humidity
    input  logic [55:0] s_tdata,
    // Compensated result output.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] temperature_centi, [63:32] pressure_scaled, [80:64] humidity_q10
    output logic [87:0] m_tdata,
    // [0] pressure_divisor_zero
    output logic [0:0]  m_tuser
);

    logic [47:0] temp_cal_reg, press_cal_a_reg, press_cal_b_reg, press_cal_c_reg;
    logic [63:0] hum_cal_reg;

    logic        ce;
    logic        fe_valid, dv_valid, be_valid;
    div_in_t     fe_data;
    div_out_t    dv_data;
    logic [31:0] temp_out, press_out;
    logic [16:0] hum_out;
    logic        dz_out;

    // Calibration registers; writes to unused indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_cal_reg    <= '0;
            press_cal_a_reg <= '0;
            press_cal_b_reg <= '0;
            press_cal_c_reg <= '0;
            hum_cal_reg     <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TEMP_CAL: temp_cal_reg    <= cfg_data[47:0];
                CFG_PRESS_A:  press_cal_a_reg <= cfg_data[47:0];
                CFG_PRESS_B:  press_cal_b_reg <= cfg_data[47:0];
                CFG_PRESS_C:  press_cal_c_reg <= cfg_data[47:0];
                CFG_HUM_CAL:  hum_cal_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The last back-end stage is the result register.
    assign ce       = !be_valid || m_tready;
    assign s_tready = ce;

    tsc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ce              (ce),
        .in_valid        (s_tvalid),
        .raw_pressure    (s_tdata[19:0]),
        .raw_temperature (s_tdata[39:20]),
        .raw_humidity    (s_tdata[55:40]),
        .temp_cal        (temp_cal_reg),
        .press_cal_a     (press_cal_a_reg),
        .press_cal_b     (press_cal_b_reg),
        .hum_cal         (hum_cal_reg),
        .out_valid       (fe_valid),
        .out_data        (fe_data)
    );

    tsc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (fe_valid),
        .in_data   (fe_data),
        .out_valid (dv_valid),
        .out_data  (dv_data)
    );

    tsc_back u_back (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .ce                    (ce),
        .in_valid              (dv_valid),
        .in_data               (dv_data),
        .press_cal_c           (press_cal_c_reg),
        .out_valid             (be_valid),
        .temperature_centi     (temp_out),
        .pressure_scaled       (press_out),
        .humidity_q10          (hum_out),
        .pressure_divisor_zero (dz_out)
    );

    assign m_tvalid = be_valid;
    assign m_tdata  = {7'd0, hum_out, press_out, temp_out};
    assign m_tuser  = dz_out;

    `TSC_ASSERT(a_dz_gives_zero, (m_tvalid && m_tuser[0]) |-> (m_tdata[63:32] == 32'd0), "pressure not zero on zero divisor")
    `TSC_ASSERT(a_hum_in_range, m_tvalid |-> (m_tdata[80:64] <= 17'd102400), "humidity above clamp")

endmodule

// ----- rtl/tsc_front.sv -----
// Temperature, humidity and pressure pre-division stages.
`timescale 1ns / 1ps
module tsc_front import tsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        ce,
    input  logic        in_valid,
    input  logic [19:0] raw_pressure,
    input  logic [19:0] raw_temperature,
    input  logic [15:0] raw_humidity,
    input  logic [47:0] temp_cal,
    input  logic [47:0] press_cal_a,
    input  logic [47:0] press_cal_b,
    input  logic [63:0] hum_cal,
    output logic        out_valid,
    output div_in_t     out_data
);

    typedef struct packed {
        logic [19:0] rp;
        logic [15:0] rh;
        logic [31:0] ma;
        logic [31:0] dd;
        logic [31:0] va;
        logic [31:0] mb;
        logic [31:0] tf;
        logic [31:0] temp;
        logic [63:0] sq;
        logic [63:0] m5;
        logic [63:0] m2;
        logic [31:0] h5v;
        logic [31:0] y1m;
        logic [31:0] y2m;
        logic [63:0] m6;
        logic [63:0] m3;
        logic [31:0] hx;
        logic [31:0] hy1;
        logic [31:0] hy2;
        logic [63:0] x2;
        logic [63:0] x1b;
        logic [31:0] ym;
        logic [63:0] dp;
        logic [63:0] num0;
        logic [31:0] yh;
        logic [63:0] divs;
        logic [63:0] numm;
        logic [31:0] hv2;
        logic [63:0] ua;
        logic [63:0] ub;
        logic        neg;
        logic        dz;
        logic [31:0] ss;
        logic [31:0] ht;
        logic [16:0] hum;
    } fe_t;

    fe_t               st_reg  [FE_DEPTH];
    fe_t               st_next [FE_DEPTH];
    logic [FE_DEPTH-1:0] vld_reg;

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, h2;
    logic [7:0]         h1, h3;
    logic signed [11:0] h4, h5;
    logic signed [7:0]  h6;

    assign t1 = temp_cal[15:0];
    assign t2 = $signed(temp_cal[31:16]);
    assign t3 = $signed(temp_cal[47:32]);
    assign p1 = press_cal_a[15:0];
    assign p2 = $signed(press_cal_a[31:16]);
    assign p3 = $signed(press_cal_a[47:32]);
    assign p4 = $signed(press_cal_b[15:0]);
    assign p5 = $signed(press_cal_b[31:16]);
    assign p6 = $signed(press_cal_b[47:32]);
    assign h1 = hum_cal[7:0];
    assign h2 = $signed(hum_cal[23:8]);
    assign h3 = hum_cal[31:24];
    assign h4 = $signed(hum_cal[43:32]);
    assign h5 = $signed(hum_cal[55:44]);
    assign h6 = $signed(hum_cal[63:56]);

    always_comb begin
        logic signed [17:0] dt, dv;
        logic signed [33:0] pr_a;
        logic signed [35:0] pr_d;
        logic signed [31:0] s12;
        logic signed [47:0] pr_b;
        logic [31:0]        t5, hv, hs, yv, v;
        logic signed [32:0] x1;
        logic signed [65:0] sq66;
        logic signed [48:0] m5w, m2w;
        logic signed [43:0] pr44;
        logic signed [39:0] pr40;
        logic signed [40:0] pr41;
        logic signed [63:0] pr64;
        logic signed [47:0] pr48;
        logic [20:0]        pp;
        logic signed [31:0] s15;
        logic signed [40:0] pr_h1;

        for (int k = 1; k < FE_DEPTH; k++) begin
            st_next[k] = st_reg[k-1];
        end

        // Stage 0: first temperature products.
        st_next[0]    = '0;
        st_next[0].rp = raw_pressure;
        st_next[0].rh = raw_humidity;
        dt   = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
        dv   = $signed({2'b0, raw_temperature[19:4]}) - $signed({2'b0, t1});
        pr_a = dt * t2;
        pr_d = dv * dv;
        st_next[0].ma = pr_a[31:0];
        st_next[0].dd = pr_d[31:0];

        // Stage 1.
        st_next[1].va = $signed(st_reg[0].ma) >>> 11;
        s12  = $signed(st_reg[0].dd) >>> 12;
        pr_b = s12 * t3;
        st_next[1].mb = pr_b[31:0];

        // Stage 2: fine temperature.
        st_next[2].tf = st_reg[1].va + 32'($signed(st_reg[1].mb) >>> 14);

        // Stage 3: temperature result and first pressure and humidity products.
        t5 = st_reg[2].tf + {st_reg[2].tf[29:0], 2'b00} + 32'd128;
        st_next[3].temp = $signed(t5) >>> 8;
        x1   = $signed({st_reg[2].tf[31], st_reg[2].tf}) - $signed(PRESS_T_OFFSET);
        sq66 = x1 * x1;
        m5w  = x1 * p5;
        m2w  = x1 * p2;
        st_next[3].sq = sq66[63:0];
        st_next[3].m5 = 64'(m5w);
        st_next[3].m2 = 64'(m2w);
        hv   = st_reg[2].tf - HUM_T_OFFSET;
        pr44 = h5 * $signed(hv);
        pr40 = $signed(hv) * h6;
        pr41 = $signed(hv) * $signed({1'b0, h3});
        st_next[3].h5v = pr44[31:0];
        st_next[3].y1m = pr40[31:0];
        st_next[3].y2m = pr41[31:0];

        // Stage 4.
        st_next[4].m6 = mul_lo(st_reg[3].sq, {p6[15], p6});
        st_next[4].m3 = mul_lo(st_reg[3].sq, {p3[15], p3});
        hs = {2'b00, st_reg[3].rh, 14'd0} - {h4, 20'd0} - st_reg[3].h5v + 32'd16384;
        st_next[4].hx  = $signed(hs) >>> 15;
        st_next[4].hy1 = $signed(st_reg[3].y1m) >>> 10;
        st_next[4].hy2 = 32'($signed(st_reg[3].y2m) >>> 11) + 32'd32768;

        // Stage 5.
        st_next[5].x2 = st_reg[4].m6 + {st_reg[4].m5[46:0], 17'd0}
                      + {{13{p4[15]}}, p4, 35'd0};
        st_next[5].x1b = 64'($signed(st_reg[4].m3) >>> 8) + {st_reg[4].m2[51:0], 12'd0}
                       + {16'd0, 1'b1, 47'd0};
        pr64 = $signed(st_reg[4].hy1) * $signed(st_reg[4].hy2);
        st_next[5].ym = pr64[31:0];

        // Stage 6: pressure divisor product and numerator.
        st_next[6].dp = mul_lo(st_reg[5].x1b, {1'b0, p1});
        pp = PRESS_FULL - {1'b0, st_reg[5].rp};
        st_next[6].num0 = {12'd0, pp, 31'd0} - st_reg[5].x2;
        yv   = 32'($signed(st_reg[5].ym) >>> 10) + HUM_Y_BIAS;
        pr48 = $signed(yv) * h2;
        st_next[6].yh = pr48[31:0];

        // Stage 7.
        st_next[7].divs = $signed(st_reg[6].dp) >>> 33;
        st_next[7].numm = mul_lo(st_reg[6].num0, $signed(PRESS_K3125));
        yv   = $signed(st_reg[6].yh + 32'd8192) >>> 14;
        pr64 = $signed(st_reg[6].hx) * $signed(yv);
        st_next[7].hv2 = pr64[31:0];

        // Stage 8: sign and magnitude for the divider.
        st_next[8].neg = st_reg[7].numm[63] ^ st_reg[7].divs[63];
        st_next[8].ua  = st_reg[7].numm[63] ? -st_reg[7].numm : st_reg[7].numm;
        st_next[8].ub  = st_reg[7].divs[63] ? -st_reg[7].divs : st_reg[7].divs;
        st_next[8].dz  = (st_reg[7].divs == 64'd0);
        s15  = $signed(st_reg[7].hv2) >>> 15;
        pr64 = s15 * s15;
        st_next[8].ss = pr64[31:0];

        // Stage 9.
        pr_h1 = $signed(st_reg[8].ss) >>> 7;
        pr_h1 = pr_h1 * $signed({1'b0, h1});
        st_next[9].ht = pr_h1[31:0];

        // Stage 10: humidity clamp.
        v = st_reg[9].hv2 - 32'($signed(st_reg[9].ht) >>> 4);
        if (v[31]) begin
            v = 32'd0;
        end else if (v > HUM_CLAMP) begin
            v = HUM_CLAMP;
        end
        st_next[10].hum = v[28:12];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[FE_DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            st_reg <= st_next;
        end
    end

    assign out_valid          = vld_reg[FE_DEPTH-1];
    assign out_data.ua        = st_reg[FE_DEPTH-1].ua;
    assign out_data.ub        = st_reg[FE_DEPTH-1].ub;
    assign out_data.side.temp = st_reg[FE_DEPTH-1].temp;
    assign out_data.side.hum  = st_reg[FE_DEPTH-1].hum;
    assign out_data.side.neg  = st_reg[FE_DEPTH-1].neg;
    assign out_data.side.dz   = st_reg[FE_DEPTH-1].dz;

endmodule

// ----- rtl/tsc_div.sv -----
// Pipelined radix-2 restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tsc_div import tsc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     ce,
    input  logic     in_valid,
    input  div_in_t  in_data,
    output logic     out_valid,
    output div_out_t out_data
);

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] dvd;
        logic [63:0] ub;
        side_t       side;
    } dstage_t;

    dstage_t               dv_reg  [DIV_STAGES];
    dstage_t               dv_next [DIV_STAGES];
    logic [DIV_STAGES-1:0] vld_reg;

    always_comb begin
        dstage_t    cur;
        logic [64:0] sh;
        logic [64:0] diff;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                cur.rem  = 64'd0;
                cur.dvd  = in_data.ua;
                cur.ub   = in_data.ub;
                cur.side = in_data.side;
            end else begin
                cur = dv_reg[k-1];
            end
            sh   = {cur.rem, cur.dvd[63]};
            diff = sh - {1'b0, cur.ub};
            dv_next[k] = cur;
            if (!diff[64]) begin
                dv_next[k].rem = diff[63:0];
                dv_next[k].dvd = {cur.dvd[62:0], 1'b1};
            end else begin
                dv_next[k].rem = sh[63:0];
                dv_next[k].dvd = {cur.dvd[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dv_reg <= dv_next;
        end
    end

    assign out_valid     = vld_reg[DIV_STAGES-1];
    assign out_data.qu   = dv_reg[DIV_STAGES-1].dvd;
    assign out_data.side = dv_reg[DIV_STAGES-1].side;

    `TSC_ASSERT_NEVER(a_rem_below_divisor, vld_reg[DIV_STAGES-1] && (dv_reg[DIV_STAGES-1].ub != 64'd0) && (dv_reg[DIV_STAGES-1].rem >= dv_reg[DIV_STAGES-1].ub), "divider remainder not below divisor")

endmodule

// ----- rtl/tsc_back.sv -----
// Pressure stages after the division, including the final divide by 100.
`timescale 1ns / 1ps
module tsc_back import tsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        ce,
    input  logic        in_valid,
    input  div_out_t    in_data,
    input  logic [47:0] press_cal_c,
    output logic        out_valid,
    output logic [31:0] temperature_centi,
    output logic [31:0] pressure_scaled,
    output logic [16:0] humidity_q10,
    output logic        pressure_divisor_zero
);

    typedef struct packed {
        logic [63:0] q;
        logic [63:0] a;
        logic [63:0] pa;
        logic [63:0] pb;
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
        logic [63:0] sum;
        logic [31:0] u32;
        logic        neg32;
        logic [63:0] prod;
        logic [31:0] press;
        side_t       side;
    } be_t;

    be_t                 st_reg  [BE_DEPTH];
    be_t                 st_next [BE_DEPTH];
    logic [BE_DEPTH-1:0] vld_reg;

    logic signed [15:0] p7, p8, p9;

    assign p7 = $signed(press_cal_c[15:0]);
    assign p8 = $signed(press_cal_c[31:16]);
    assign p9 = $signed(press_cal_c[47:32]);

    always_comb begin
        logic [63:0] full, p64, q;
        logic [31:0] p32;
        logic [26:0] qq;

        for (int k = 1; k < BE_DEPTH; k++) begin
            st_next[k] = st_reg[k-1];
        end

        // Stage 0: restore the quotient sign.
        st_next[0]      = '0;
        st_next[0].side = in_data.side;
        q = in_data.side.neg ? -in_data.qu : in_data.qu;
        st_next[0].q = q;
        st_next[0].a = $signed(q) >>> 13;

        // Stage 1.
        st_next[1].pa = mul_lo(st_reg[0].a, {p9[15], p9});
        st_next[1].pb = mul_lo(st_reg[0].q, {p8[15], p8});

        // Stage 2: partial products of the 64-bit square term.
        st_next[2].ll = st_reg[1].pa[31:0] * st_reg[1].a[31:0];
        p64 = st_reg[1].pa[31:0] * st_reg[1].a[63:32];
        st_next[2].lh = p64[31:0];
        p64 = st_reg[1].pa[63:32] * st_reg[1].a[31:0];
        st_next[2].hl = p64[31:0];

        // Stage 3.
        full = st_reg[2].ll + {st_reg[2].lh + st_reg[2].hl, 32'd0};
        st_next[3].sum = st_reg[2].q + 64'($signed(full) >>> 25)
                       + 64'($signed(st_reg[2].pb) >>> 19);

        // Stage 4: Q24.8 value cut to 32 bits, split into sign and magnitude.
        p64 = 64'($signed(st_reg[3].sum) >>> 8) + {{44{p7[15]}}, p7, 4'd0};
        p32 = p64[31:0];
        st_next[4].neg32 = p32[31];
        st_next[4].u32   = p32[31] ? -p32 : p32;

        // Stage 5: divide by 100 through the scaled reciprocal.
        st_next[5].prod = st_reg[4].u32 * RECIP_100;

        // Stage 6.
        qq = st_reg[5].prod[RECIP_SHIFT +: 27];
        if (st_reg[5].side.dz) begin
            st_next[6].press = 32'd0;
        end else if (st_reg[5].neg32) begin
            st_next[6].press = -{5'd0, qq};
        end else begin
            st_next[6].press = {5'd0, qq};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[BE_DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            st_reg <= st_next;
        end
    end

    assign out_valid             = vld_reg[BE_DEPTH-1];
    assign temperature_centi     = st_reg[BE_DEPTH-1].side.temp;
    assign pressure_scaled       = st_reg[BE_DEPTH-1].press;
    assign humidity_q10          = st_reg[BE_DEPTH-1].side.hum;
    assign pressure_divisor_zero = st_reg[BE_DEPTH-1].side.dz;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the sensor compensation pipeline.
`timescale 1ns / 1ps
module tb_top;
    import tsc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES = 400;

    // One compensated reading as the block should return it.
    typedef struct {
        logic [31:0] temp_centi;
        logic [31:0] press_scaled;
        logic [16:0] hum_q10;
        logic        div_zero;
    } reading_t;

    // Keeps a private copy of the calibration words, computes the expected
    // reading for every accepted sample and compares each returned one.
    class sensor_scoreboard;
        logic [63:0] cal[5];
        reading_t    pending_q[$];
        int          errors;
        int          checked;
        int          div_zero_seen;

        function new();
            foreach (cal[i]) cal[i] = '0;
            errors = 0;
            checked = 0;
            div_zero_seen = 0;
        endfunction

        function void write_cal(logic [2:0] idx, logic [63:0] val);
            if (idx < CFG_HUM_CAL) cal[idx] = {16'd0, val[47:0]};
            else if (idx == CFG_HUM_CAL) cal[idx] = val;
        endfunction

        function logic [31:0] asr(logic [31:0] a, int s);
            return $signed(a) >>> s;
        endfunction

        function reading_t compensate(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
            reading_t r;
            logic [31:0] t1, t2, t3, m, va, vb, d, tf, rt32;
            logic signed [63:0] x1, x2, pv, av, p1, p2, p3, p4, p5, p6, p7, p8, p9;
            logic [63:0] ua, ub, q;
            logic [31:0] w, u;
            logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y, y1, y2, s;
            logic [63:0] tc, pa, pb, pc, hc;
            tc = cal[CFG_TEMP_CAL];
            pa = cal[CFG_PRESS_A];
            pb = cal[CFG_PRESS_B];
            pc = cal[CFG_PRESS_C];
            hc = cal[CFG_HUM_CAL];

            // Temperature, all 32-bit wrapping.
            rt32 = {12'd0, rt};
            t1 = {16'd0, tc[15:0]};
            t2 = {{16{tc[31]}}, tc[31:16]};
            t3 = {{16{tc[47]}}, tc[47:32]};
            m = ((rt32 >> 3) - (t1 << 1)) * t2;
            va = asr(m, 11);
            d = (rt32 >> 4) - t1;
            m = asr(d * d, 12) * t3;
            vb = asr(m, 14);
            tf = va + vb;
            r.temp_centi = asr(tf * 32'd5 + 32'd128, 8);

            // Pressure, all 64-bit wrapping.
            p1 = {48'd0, pa[15:0]};
            p2 = {{48{pa[31]}}, pa[31:16]};
            p3 = {{48{pa[47]}}, pa[47:32]};
            p4 = {{48{pb[15]}}, pb[15:0]};
            p5 = {{48{pb[31]}}, pb[31:16]};
            p6 = {{48{pb[47]}}, pb[47:32]};
            p7 = {{48{pc[15]}}, pc[15:0]};
            p8 = {{48{pc[31]}}, pc[31:16]};
            p9 = {{48{pc[47]}}, pc[47:32]};
            x1 = $signed({{32{tf[31]}}, tf}) - 64'sd128000;
            x2 = x1 * x1 * p6 + ((x1 * p5) <<< 17) + (p4 <<< 35);
            x1 = ((x1 * x1 * p3) >>> 8) + ((x1 * p2) <<< 12);
            x1 = ((64'sh0000_8000_0000_0000 + x1) * p1) >>> 33;
            if (x1 == 0) begin
                r.div_zero = 1'b1;
                r.press_scaled = '0;
            end else begin
                r.div_zero = 1'b0;
                pv = 64'sd1048576 - $signed({44'd0, rp});
                pv = ((pv <<< 31) - x2) * 64'sd3125;
                // Truncating signed division; the most negative value over -1 wraps.
                ua = pv[63] ? -pv : pv;
                ub = x1[63] ? -x1 : x1;
                q = ua / ub;
                if (pv[63] != x1[63]) q = -q;
                pv = q;
                av = pv >>> 13;
                x1 = (p9 * av * av) >>> 25;
                x2 = (p8 * pv) >>> 19;
                pv = ((pv + x1 + x2) >>> 8) + (p7 <<< 4);
                w = pv[31:0];
                u = w[31] ? -w : w;
                u = u / 32'd100;
                r.press_scaled = w[31] ? -u : u;
            end

            // Humidity, all 32-bit wrapping.
            h1 = {24'd0, hc[7:0]};
            h2 = {{16{hc[23]}}, hc[23:8]};
            h3 = {24'd0, hc[31:24]};
            h4 = {{20{hc[43]}}, hc[43:32]};
            h5 = {{20{hc[55]}}, hc[55:44]};
            h6 = {{24{hc[63]}}, hc[63:56]};
            v = tf - 32'd76800;
            x = asr(({16'd0, rh} << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
            y1 = asr(v * h6, 10);
            y2 = asr(v * h3, 11) + 32'd32768;
            y = asr(y1 * y2, 10) + 32'd2097152;
            y = asr(y * h2 + 32'd8192, 14);
            v = x * y;
            s = asr(v, 15);
            v = v - asr(asr(s * s, 7) * h1, 4);
            if (v[31]) v = '0;
            else if (v > 32'd419430400) v = 32'd419430400;
            r.hum_q10 = v[28:12];
            return r;
        endfunction

        function void note_sample(logic [55:0] data);
            pending_q.push_back(compensate(data[19:0], data[39:20], data[55:40]));
        endfunction

        function void check_result(logic [87:0] data, logic [0:0] user);
            reading_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata=%h tuser=%b",
                         $time, data, user);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (user[0]) div_zero_seen++;
            if (data[31:0] !== e.temp_centi) begin
                $display("%0t: temperature mismatch, expected %0d, actual %0d", $time,
                         $signed(e.temp_centi), $signed(data[31:0]));
                errors++;
            end
            if (data[63:32] !== e.press_scaled) begin
                $display("%0t: pressure mismatch, expected %0d, actual %0d", $time,
                         $signed(e.press_scaled), $signed(data[63:32]));
                errors++;
            end
            if (data[80:64] !== e.hum_q10) begin
                $display("%0t: humidity mismatch, expected %0d, actual %0d", $time,
                         e.hum_q10, data[80:64]);
                errors++;
            end
            if (user[0] !== e.div_zero) begin
                $display("%0t: divisor-zero flag mismatch, expected %b, actual %b", $time,
                         e.div_zero, user[0]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [0:0]  m_tuser;

    sensor_scoreboard sb = new();
    bit  hold_req = 1'b0;
    bit  rx_steady = 1'b0;
    bit  tx_steady = 1'b0;
    int  cycles = 0;
    int  samples_sent = 0;

    tph_sensor_compensation i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Global watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** tph_sensor_compensation: FAILED **");
            $finish;
        end
    end

    // Signals are driven at the rising edge and sampled at the falling edge,
    // so a transaction seen here completes at the next rising edge.
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13) return 0;
        if (r < 18) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Result-side back-pressure: random ready patterns, plus one long
    // hold-off on request so that the pipeline fills and blocks its input.
    initial begin
        int n;
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (rx_steady) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge aclk);
                n = pick_gap();
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
            end
        end
    end

    // One register write; the caller drops the write enable after the last one.
    task automatic write_cal(logic [2:0] idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        sb.write_cal(idx, val);
    endtask

    task automatic load_cal(logic [63:0] tcal, logic [63:0] pa, logic [63:0] pb,
                            logic [63:0] pc, logic [63:0] hcal);
        write_cal(CFG_TEMP_CAL, tcal);
        write_cal(CFG_PRESS_A, pa);
        write_cal(CFG_PRESS_B, pb);
        write_cal(CFG_PRESS_C, pc);
        write_cal(CFG_HUM_CAL, hcal);
        cfg_we <= 1'b0;
    endtask

    // Offers one sample and returns once the transaction has completed,
    // leaving valid high when the next sample follows without a gap.
    task automatic send_sample(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {rh, rt, rp};
        do @(negedge aclk); while (!s_tready);
        sb.note_sample({rh, rt, rp});
        samples_sent++;
        @(posedge aclk);
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Sender stops until every expected result has been returned.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_random(int count, bit typical);
        repeat (count) begin
            if (typical && $urandom_range(0, 3) != 0)
                send_sample(20'd415148 + 20'($urandom_range(0, 40000)) - 20'd20000,
                            20'd519888 + 20'($urandom_range(0, 60000)) - 20'd30000,
                            16'd27000 + 16'($urandom_range(0, 20000)) - 16'd10000);
            else
                send_sample(20'($urandom), 20'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        logic [63:0] r0, r1, r2, r3, r4;
        logic [2:0]  bad_idx;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset calibration is all zero, so every divisor is zero.
        send_sample('0, '0, '0);
        send_sample('1, '1, '1);
        send_sample(20'h5A5A5, 20'hA5A5A, 16'h3C3C);
        drain();

        // Datasheet-like calibration; indexes past the last register must be ignored.
        load_cal({16'hFC18, 16'd26435, 16'd27504},
                 {16'd3024, 16'hD643, 16'd36477},
                 {16'hFFF9, 16'd140, 16'd2855},
                 {16'd6000, 16'hC6F8, 16'd15500},
                 {8'd30, 12'd0, 12'd324, 8'd0, 16'd362, 8'd75});
        for (bad_idx = CFG_HUM_CAL + 3'd1; bad_idx != 3'd0; bad_idx++)
            write_cal(bad_idx, '1);
        cfg_we <= 1'b0;
        send_sample(20'd415148, 20'd519888, 16'd27000);
        send_sample('0, 20'd519888, 16'd27000);
        send_sample('1, 20'd519888, 16'd27000);
        send_sample(20'd415148, '0, 16'd27000);
        send_sample(20'd415148, '1, 16'd27000);
        send_sample(20'd415148, 20'd519888, '0);
        send_sample(20'd415148, 20'd519888, '1);
        send_sample(20'h80000, 20'h80000, 16'h8000);
        send_sample('1, '1, '1);
        send_sample('0, '0, '0);
        drain();

        // Typical traffic with one long result-side stall while samples keep coming.
        hold_req = 1'b1;
        send_random(100, 1'b1);
        drain();

        // Extreme calibration: signed minimum words and unsigned maxima.
        load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'hFFFF},
                 {16'h8000, 16'h8000, 16'h8000}, {16'h8000, 16'h8000, 16'h8000},
                 {8'h80, 12'h800, 12'h800, 8'hFF, 16'h8000, 8'hFF});
        send_sample('0, '0, '0);
        send_sample('1, '1, '1);
        rx_steady = 1'b1;
        tx_steady = 1'b1;
        send_random(40, 1'b0);
        drain();
        rx_steady = 1'b0;
        tx_steady = 1'b0;

        // All ones, then signed maxima.
        load_cal('1, '1, '1, '1, '1);
        send_random(30, 1'b0);
        drain();
        load_cal({16'h7FFF, 16'h7FFF, 16'h0000}, {16'h7FFF, 16'h7FFF, 16'h0000},
                 {16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF},
                 {8'h7F, 12'h7FF, 12'h7FF, 8'h00, 16'h7FFF, 8'h00});
        send_random(30, 1'b0);
        drain();

        // Random calibrations, each followed by mostly realistic samples.
        repeat (4) begin
            r0 = {$urandom, $urandom};
            r1 = {$urandom, $urandom};
            r2 = {$urandom, $urandom};
            r3 = {$urandom, $urandom};
            r4 = {$urandom, $urandom};
            if ($urandom_range(0, 1)) r0[31:0] = {16'd26435, 16'd27504};
            load_cal(r0, r1, r2, r3, r4);
            send_random(50, 1'b1);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d samples over reset, typical, extreme and random calibrations;",
                 samples_sent);
        $display("checked %0d results, %0d with a zero pressure divisor.",
                 sb.checked, sb.div_zero_seen);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("** tph_sensor_compensation: PASSED **");
        end else begin
            $display("** tph_sensor_compensation: FAILED **");
        end
        $finish;
    end
endmodule
